@@ hdl/file_type_sniffer_defines.svh @@
// Assertion macros for the file type sniffer.
// Used by the top level; relies on clk and rst_n being in scope.
`ifndef FILE_TYPE_SNIFFER_DEFINES_SVH
`define FILE_TYPE_SNIFFER_DEFINES_SVH
`ifndef SYNTHESIS
`define FTS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("file_type_sniffer assertion failed");
`define FTS_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("file_type_sniffer assertion failed");
`else
`define FTS_ASSERT(lbl, prop)
`define FTS_ASSERT_NEXT(lbl, cond, prop)
`endif
`endif

@@ hdl/fts_pkg.sv @@
// Types, codes, signatures and the byte classifier of the file type sniffer.
// No dependencies.
package fts_pkg;

    typedef logic [4:0] ftype_t;

    localparam ftype_t FT_UNKNOWN = 5'd0;
    localparam ftype_t FT_PNG     = 5'd1;
    localparam ftype_t FT_ARCHIVE = 5'd2;
    localparam ftype_t FT_GIF     = 5'd3;
    localparam ftype_t FT_QIF     = 5'd4;
    localparam ftype_t FT_PDF     = 5'd5;
    localparam ftype_t FT_OFFICE  = 5'd6;
    localparam ftype_t FT_ELF     = 5'd7;
    localparam ftype_t FT_JPEG    = 5'd8;
    localparam ftype_t FT_EXIF    = 5'd9;
    localparam ftype_t FT_PS      = 5'd10;
    localparam ftype_t FT_ZIP     = 5'd11;
    localparam ftype_t FT_SHELL   = 5'd12;
    localparam ftype_t FT_MZ      = 5'd13;
    localparam ftype_t FT_ZM      = 5'd14;
    localparam ftype_t FT_TEXT    = 5'd15;
    localparam ftype_t FT_CSV     = 5'd16;
    localparam ftype_t FT_OFX     = 5'd17;

    typedef enum logic [2:0] {
        CL_NOPRINT = 3'd0,
        CL_ALPHA   = 3'd1,
        CL_NUMBER  = 3'd2,
        CL_PUNCT   = 3'd3,
        CL_OTHER   = 3'd4
    } char_class_t;

    localparam int NCLASS = 5;
    localparam int HDR_LEN = 10;
    localparam int WIN_LEN = 16;

    // Header signatures, byte at offset zero in the low bits.
    localparam logic [63:0] SIG_PNG    = 64'h0a1a0a0d474e5089;
    localparam logic [55:0] SIG_ARCH   = 56'h3e686372613c21;
    localparam logic [47:0] SIG_GIF89  = 48'h613938464947;
    localparam logic [47:0] SIG_GIF87  = 48'h613738464947;
    localparam logic [47:0] SIG_QIF    = 48'h3a6570795421;
    localparam logic [31:0] SIG_PDF    = 32'h46445025;
    localparam logic [31:0] SIG_OFFICE = 32'he011cfd0;
    localparam logic [31:0] SIG_ELF    = 32'h464c457f;
    localparam logic [23:0] SIG_JPEG   = 24'hffd8ff;
    localparam logic [15:0] SIG_PS     = 16'h2125;
    localparam logic [15:0] SIG_ZIP    = 16'h4b50;
    localparam logic [15:0] SIG_SHELL  = 16'h2123;
    localparam logic [15:0] SIG_MZ     = 16'h5a4d;
    localparam logic [15:0] SIG_ZM     = 16'h4d5a;
    localparam logic [31:0] SIG_EXIF   = 32'h66697845;

    // Window patterns, newest byte in the low bits.
    localparam logic [111:0] PAT_XML  = "<?xml version=";
    localparam logic [127:0] PAT_OFX1 = "<?OFX OFXHEADER=";
    localparam logic [79:0]  PAT_OFX2 = "OFXHEADER:";

    typedef struct packed {
        logic [8*HDR_LEN-1:0] hdr;
        logic                 csv_comma;
        logic                 ofx_found;
        logic                 png_found;
        logic [15:0]          png_w;
        logic [15:0]          png_h;
        logic                 jpeg_found;
        logic [15:0]          jpeg_w;
        logic [15:0]          jpeg_h;
    } snap_t;

    function automatic char_class_t char_class(input logic [7:0] b);
        char_class_t c;
        if (b inside {8'h09, 8'h0a, 8'h0d}) c = CL_ALPHA;
        else if (b < 8'h20 || b > 8'h7f) c = CL_NOPRINT;
        else if (b inside {[8'h41:8'h5a], [8'h61:8'h7a], 8'h20}) c = CL_ALPHA;
        else if (b inside {[8'h30:8'h39], 8'h2d}) c = CL_NUMBER;
        else if (b inside {8'h2e, 8'h2c, 8'h3b, 8'h3a, 8'h3c, 8'h3e, 8'h2f,
                           8'h5b, 8'h5d, 8'h22, 8'h24, 8'h23, 8'h3f, 8'h3d})
            c = CL_PUNCT;
        else c = CL_OTHER;
        return c;
    endfunction

endpackage

@@ hdl/fts_if.sv @@
// Valid/ready channels of the file type sniffer: input bytes and results.
// Depends on fts_pkg.
interface fts_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, data_byte, last_byte, input ready);
    modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface fts_result_if;
    logic            valid;
    logic            ready;
    fts_pkg::ftype_t file_type;
    logic            executable;
    logic [15:0]     image_width;
    logic [15:0]     image_height;
    logic [31:0]     image_area;
    modport source (output valid, file_type, executable, image_width, image_height,
                    image_area, input ready);
    modport sink (input valid, file_type, executable, image_width, image_height,
                  image_area, output ready);
endinterface

@@ hdl/fts_scan.sv @@
// Input register and per-buffer scan state: header, window, counts and flags.
// Depends on fts_pkg and fts_if.
module fts_scan #(
    parameter int MAX_BYTES = 16384,
    parameter int CW = $clog2(MAX_BYTES + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    fts_byte_if.sink       bytes,
    input  logic           finish_ok,
    output logic           done,
    output fts_pkg::snap_t snap,
    output logic [CW-1:0]  n,
    output logic [CW-1:0]  cnt [fts_pkg::NCLASS]
);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BYTES);

    logic                        a_valid_reg;
    logic [7:0]                  a_byte_reg;
    logic                        a_last_reg;
    logic                        a_fire;
    logic [8*fts_pkg::HDR_LEN-1:0] hdr_reg, hdr_next;
    logic [8*fts_pkg::WIN_LEN-1:0] win_reg, win_next;
    logic [CW-1:0]               pos_reg, pos_next;
    logic [CW-1:0]               cnt_reg [fts_pkg::NCLASS];
    logic [CW-1:0]               cnt_next [fts_pkg::NCLASS];
    logic                        quoted_reg, quoted_next;
    logic                        ended_reg, ended_next;
    logic                        comma_reg, comma_next;
    logic                        found_reg, found_next;
    logic                        nul_reg, nul_next;
    logic                        png_f_reg, png_f_next, jpg_f_reg, jpg_f_next;
    logic [15:0]                 png_w_reg, png_w_next, png_h_reg, png_h_next;
    logic [15:0]                 jpg_w_reg, jpg_w_next, jpg_h_reg, jpg_h_next;
    logic                        absorb;
    logic                        pat_hit;
    logic [7:0]                  b;
    fts_pkg::char_class_t        cls;

    assign a_fire = a_valid_reg && (!a_last_reg || finish_ok);
    assign bytes.ready = !a_valid_reg || a_fire;
    assign done = a_fire && a_last_reg;
    assign b = a_byte_reg;
    assign cls = fts_pkg::char_class(b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (bytes.ready)
        begin
            a_valid_reg <= bytes.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.ready && bytes.valid)
        begin
            a_byte_reg <= bytes.data_byte;
            a_last_reg <= bytes.last_byte;
        end
    end

    always_comb
    begin
        absorb = pos_reg < MAXC;
        hdr_next = hdr_reg;
        win_next = win_reg;
        pos_next = pos_reg;
        cnt_next = cnt_reg;
        quoted_next = quoted_reg;
        ended_next = ended_reg;
        comma_next = comma_reg;
        found_next = found_reg;
        nul_next = nul_reg;
        png_f_next = png_f_reg;
        png_w_next = png_w_reg;
        png_h_next = png_h_reg;
        jpg_f_next = jpg_f_reg;
        jpg_w_next = jpg_w_reg;
        jpg_h_next = jpg_h_reg;
        pat_hit = 1'b0;
        if (absorb)
        begin
            for (int i = 0; i < fts_pkg::HDR_LEN; i++)
            begin
                if (pos_reg == CW'(i))
                begin
                    hdr_next[8*i +: 8] = b;
                end
            end
            win_next = {win_reg[8*fts_pkg::WIN_LEN-9:0], b};
            pos_next = pos_reg + 1'b1;
            cnt_next[cls] = cnt_reg[cls] + 1'b1;
            if (!ended_reg)
            begin
                if (b == 8'h22)
                begin
                    quoted_next = !quoted_reg;
                end
                else if (b == 8'h2c && !quoted_reg)
                begin
                    comma_next = 1'b1;
                end
                else if (b == 8'h0a || b == 8'h0d)
                begin
                    ended_next = 1'b1;
                end
            end
            pat_hit = (pos_next >= CW'(14) && win_next[111:0] == fts_pkg::PAT_XML)
                   || (pos_next >= CW'(16) && win_next[127:0] == fts_pkg::PAT_OFX1)
                   || (pos_next >= CW'(10) && win_next[79:0] == fts_pkg::PAT_OFX2);
            if (b == 8'h00)
            begin
                nul_next = 1'b1;
            end
            else if (!nul_reg && !found_reg && pat_hit)
            begin
                found_next = 1'b1;
            end
            if (!png_f_reg && pos_reg >= CW'(11) && win_next[95:64] == 32'h49484452)
            begin
                png_f_next = 1'b1;
                png_w_next = win_next[47:32];
                png_h_next = win_next[15:0];
            end
            if (!jpg_f_reg && pos_reg >= CW'(9) && win_next[79:64] == 16'hffc0)
            begin
                jpg_f_next = 1'b1;
                jpg_h_next = win_next[39:24];
                jpg_w_next = win_next[23:8];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg <= '0;
            win_reg <= '0;
            pos_reg <= '0;
            for (int i = 0; i < fts_pkg::NCLASS; i++) cnt_reg[i] <= '0;
            quoted_reg <= 1'b0;
            ended_reg <= 1'b0;
            comma_reg <= 1'b0;
            found_reg <= 1'b0;
            nul_reg <= 1'b0;
            png_f_reg <= 1'b0;
            png_w_reg <= '0;
            png_h_reg <= '0;
            jpg_f_reg <= 1'b0;
            jpg_w_reg <= '0;
            jpg_h_reg <= '0;
        end
        else if (done)
        begin
            hdr_reg <= '0;
            win_reg <= '0;
            pos_reg <= '0;
            for (int i = 0; i < fts_pkg::NCLASS; i++) cnt_reg[i] <= '0;
            quoted_reg <= 1'b0;
            ended_reg <= 1'b0;
            comma_reg <= 1'b0;
            found_reg <= 1'b0;
            nul_reg <= 1'b0;
            png_f_reg <= 1'b0;
            png_w_reg <= '0;
            png_h_reg <= '0;
            jpg_f_reg <= 1'b0;
            jpg_w_reg <= '0;
            jpg_h_reg <= '0;
        end
        else if (a_fire)
        begin
            hdr_reg <= hdr_next;
            win_reg <= win_next;
            pos_reg <= pos_next;
            cnt_reg <= cnt_next;
            quoted_reg <= quoted_next;
            ended_reg <= ended_next;
            comma_reg <= comma_next;
            found_reg <= found_next;
            nul_reg <= nul_next;
            png_f_reg <= png_f_next;
            png_w_reg <= png_w_next;
            png_h_reg <= png_h_next;
            jpg_f_reg <= jpg_f_next;
            jpg_w_reg <= jpg_w_next;
            jpg_h_reg <= jpg_h_next;
        end
    end

    always_comb
    begin
        snap.hdr = hdr_next;
        snap.csv_comma = comma_next;
        snap.ofx_found = found_next;
        snap.png_found = png_f_next;
        snap.png_w = png_w_next;
        snap.png_h = png_h_next;
        snap.jpeg_found = jpg_f_next;
        snap.jpeg_w = jpg_w_next;
        snap.jpeg_h = jpg_h_next;
    end

    assign n = pos_next;
    assign cnt = cnt_next;

endmodule

@@ hdl/fts_classify.sv @@
// Classification of a finished buffer into the registered result stage.
// Depends on fts_pkg.
module fts_classify #(
    parameter int MAX_BYTES = 16384,
    parameter int CW = $clog2(MAX_BYTES + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  logic            take,
    output logic            can_load,
    input  fts_pkg::snap_t  snap,
    input  logic [CW-1:0]   n,
    input  logic [CW-1:0]   cnt [fts_pkg::NCLASS],
    output logic            b_valid,
    output fts_pkg::ftype_t b_type,
    output logic            b_exec,
    output logic [15:0]     b_w,
    output logic [15:0]     b_h
);
    logic            valid_reg;
    fts_pkg::ftype_t type_reg, type_next;
    logic            exec_reg, exec_next;
    logic [15:0]     w_reg, w_next, h_reg, h_next;
    logic [79:0]     hd;
    logic            text;
    logic [CW+4:0]   np20;
    logic [CW+3:0]   nu10;
    logic [CW+5:0]   ot50;
    logic [CW+1:0]   apn;

    assign can_load = !valid_reg || take;
    assign hd = snap.hdr;

    always_comb
    begin
        np20 = (CW+5)'(cnt[fts_pkg::CL_NOPRINT]) * (CW+5)'(20);
        nu10 = (CW+4)'(cnt[fts_pkg::CL_NUMBER]) * (CW+4)'(10);
        ot50 = (CW+6)'(cnt[fts_pkg::CL_OTHER]) * (CW+6)'(50);
        apn = (CW+2)'(cnt[fts_pkg::CL_ALPHA]) + (CW+2)'(cnt[fts_pkg::CL_NUMBER])
            + (CW+2)'(cnt[fts_pkg::CL_PUNCT]);
        text = !(np20 > (CW+5)'(n)) && !(nu10 > (CW+4)'(cnt[fts_pkg::CL_ALPHA]))
            && !(ot50 > (CW+6)'(apn));
        w_next = '0;
        h_next = '0;
        if (n >= CW'(8) && hd[63:0] == fts_pkg::SIG_PNG)
        begin
            type_next = fts_pkg::FT_PNG;
            if (snap.png_found)
            begin
                w_next = snap.png_w;
                h_next = snap.png_h;
            end
        end
        else if (n >= CW'(7) && hd[55:0] == fts_pkg::SIG_ARCH)
            type_next = fts_pkg::FT_ARCHIVE;
        else if (n >= CW'(6) && (hd[47:0] == fts_pkg::SIG_GIF89
                 || hd[47:0] == fts_pkg::SIG_GIF87))
        begin
            type_next = fts_pkg::FT_GIF;
            w_next = hd[63:48];
            h_next = hd[79:64];
        end
        else if (n >= CW'(6) && hd[47:0] == fts_pkg::SIG_QIF)
            type_next = fts_pkg::FT_QIF;
        else if (n >= CW'(4) && hd[31:0] == fts_pkg::SIG_PDF)
            type_next = fts_pkg::FT_PDF;
        else if (n >= CW'(4) && hd[31:0] == fts_pkg::SIG_OFFICE)
            type_next = fts_pkg::FT_OFFICE;
        else if (n >= CW'(4) && hd[31:0] == fts_pkg::SIG_ELF)
            type_next = fts_pkg::FT_ELF;
        else if (n >= CW'(3) && hd[23:0] == fts_pkg::SIG_JPEG)
        begin
            if (n >= CW'(10) && hd[79:48] == fts_pkg::SIG_EXIF)
                type_next = fts_pkg::FT_EXIF;
            else
            begin
                type_next = fts_pkg::FT_JPEG;
                if (snap.jpeg_found)
                begin
                    w_next = snap.jpeg_w;
                    h_next = snap.jpeg_h;
                end
            end
        end
        else if (n >= CW'(2) && hd[15:0] == fts_pkg::SIG_PS)
            type_next = fts_pkg::FT_PS;
        else if (n >= CW'(2) && hd[15:0] == fts_pkg::SIG_ZIP)
            type_next = fts_pkg::FT_ZIP;
        else if (n >= CW'(2) && hd[15:0] == fts_pkg::SIG_SHELL)
            type_next = fts_pkg::FT_SHELL;
        else if (n >= CW'(2) && hd[15:0] == fts_pkg::SIG_MZ)
            type_next = fts_pkg::FT_MZ;
        else if (n >= CW'(2) && hd[15:0] == fts_pkg::SIG_ZM)
            type_next = fts_pkg::FT_ZM;
        else if (text)
            type_next = fts_pkg::FT_TEXT;
        else if (snap.csv_comma)
            type_next = fts_pkg::FT_CSV;
        else if (snap.ofx_found)
            type_next = fts_pkg::FT_OFX;
        else
            type_next = fts_pkg::FT_UNKNOWN;
        exec_next = type_next == fts_pkg::FT_ELF || type_next == fts_pkg::FT_SHELL
                 || type_next == fts_pkg::FT_MZ || type_next == fts_pkg::FT_ZM;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && load)
        begin
            type_reg <= type_next;
            exec_reg <= exec_next;
            w_reg <= w_next;
            h_reg <= h_next;
        end
    end

    assign b_valid = valid_reg;
    assign b_type = type_reg;
    assign b_exec = exec_reg;
    assign b_w = w_reg;
    assign b_h = h_reg;

endmodule

@@ hdl/file_type_sniffer.sv @@
// Top level of the file type sniffer: scan, classify and output stages.
// Depends on fts_pkg, fts_if, fts_scan, fts_classify and the defines header.
//
//   channel  direction  payload
//   bytes    in         data_byte, last_byte
//   result   out        file_type, executable, image_width, image_height, image_area
//
// One byte is taken every cycle unless a final byte in the input register waits for
// the classification register; the scan state updates from the registered byte. Once
// its final byte is accepted, a result is offered after the scan of the input register
// loads the classification register, which then loads the area multiply register.
// Reset clears all buffer state at once. A stalled result holds the output
// register; bytes keep flowing until a further final byte finds the
// classification register full as well.
`include "file_type_sniffer_defines.svh"
module file_type_sniffer #(
    parameter int MAX_BYTES = 16384
) (
    input logic          clk,
    input logic          rst_n,
    fts_byte_if.sink     bytes,
    fts_result_if.source result
);
    localparam int CW = $clog2(MAX_BYTES + 1);

    logic            done, can_load, c_en;
    fts_pkg::snap_t  snap;
    logic [CW-1:0]   n;
    logic [CW-1:0]   cnt [fts_pkg::NCLASS];
    logic            b_valid, b_exec;
    fts_pkg::ftype_t b_type;
    logic [15:0]     b_w, b_h;
    logic            c_valid_reg;
    fts_pkg::ftype_t c_type_reg;
    logic            c_exec_reg;
    logic [15:0]     c_w_reg, c_h_reg;
    logic [31:0]     c_area_reg;

    fts_scan #(.MAX_BYTES(MAX_BYTES), .CW(CW)) u_scan (
        .clk(clk), .rst_n(rst_n), .bytes(bytes), .finish_ok(can_load), .done(done),
        .snap(snap), .n(n), .cnt(cnt)
    );

    fts_classify #(.MAX_BYTES(MAX_BYTES), .CW(CW)) u_classify (
        .clk(clk), .rst_n(rst_n), .load(done), .take(c_en), .can_load(can_load),
        .snap(snap), .n(n), .cnt(cnt), .b_valid(b_valid), .b_type(b_type),
        .b_exec(b_exec), .b_w(b_w), .b_h(b_h)
    );

    assign c_en = !c_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_en)
        begin
            c_valid_reg <= b_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_en && b_valid)
        begin
            c_type_reg <= b_type;
            c_exec_reg <= b_exec;
            c_w_reg <= b_w;
            c_h_reg <= b_h;
            c_area_reg <= 32'(b_w) * 32'(b_h);
        end
    end

    assign result.valid = c_valid_reg;
    assign result.file_type = c_type_reg;
    assign result.executable = c_exec_reg;
    assign result.image_width = c_w_reg;
    assign result.image_height = c_h_reg;
    assign result.image_area = c_area_reg;

    `FTS_ASSERT_NEXT(a_area_product, b_valid && c_en, c_valid_reg && c_area_reg == 32'($past(b_w)) * 32'($past(b_h)))
    `FTS_ASSERT(a_dims_only_images, b_valid && b_type != fts_pkg::FT_PNG && b_type != fts_pkg::FT_GIF && b_type != fts_pkg::FT_JPEG |-> b_w == 16'd0 && b_h == 16'd0)
    `FTS_ASSERT_NEXT(a_done_loads, done, b_valid)

endmodule

@@ sim/file_type_sniffer_tb.sv @@
// Self-checking testbench for the file type sniffer: byte buffers in, one classification out.
// Depends on fts_pkg, fts_if and file_type_sniffer; predicts each buffer's result in place.
`timescale 1ns / 100ps
module file_type_sniffer_tb;

    localparam int MAX_BYTES = 16384;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ITEM_TARGET = 1250;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        fts_pkg::ftype_t file_type;
        logic            executable;
        logic [15:0]     image_width;
        logic [15:0]     image_height;
        logic [31:0]     image_area;
    } verdict_t;

    logic clk;
    logic rst_n;

    fts_byte_if   bytes();
    fts_result_if result();

    file_type_sniffer #(.MAX_BYTES(MAX_BYTES)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .bytes(bytes.sink),
        .result(result.source)
    );

    byte_item_t pending_bytes[$];
    verdict_t   expected_verdicts[$];
    int         mismatch_count;
    int         buffers_checked;
    int         bytes_sent;
    int         idle_cycles;
    bit         hold_result;
    bit         byte_taken;
    bit         result_taken;
    int         in_gap;
    int         out_gap;
    int         type_seen[18];

    // Predictor state for the buffer being scanned.
    logic [7:0]  hdr[10];
    int          scan_count;
    logic [7:0]  recent[16];
    int          class_tally[5];
    bit          csv_quoted, csv_ended, csv_comma;
    bit          ofx_found, ofx_nul;
    bit          png_found, jpeg_found;
    logic [15:0] png_w, png_h, jpeg_w, jpeg_h;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int byte_class(logic [7:0] b);
        if (b == 8'h09 || b == 8'h0a || b == 8'h0d) return fts_pkg::CL_ALPHA;
        if (b < 8'h20 || b > 8'h7f) return fts_pkg::CL_NOPRINT;
        if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == " ")
            return fts_pkg::CL_ALPHA;
        if ((b >= "0" && b <= "9") || b == "-") return fts_pkg::CL_NUMBER;
        case (b)
            ".", ",", ";", ":", "<", ">", "/", "[", "]", "\"", "$", "#", "?", "=":
                return fts_pkg::CL_PUNCT;
            default:
                return fts_pkg::CL_OTHER;
        endcase
    endfunction

    function automatic bit recent_ends_with(string pat, int seen);
        int len;
        len = pat.len();
        if (seen < len) return 0;
        for (int k = 0; k < len; k++)
        begin
            if (recent[len - 1 - k] != pat[k]) return 0;
        end
        return 1;
    endfunction

    task automatic clear_scan();
        foreach (hdr[i]) hdr[i] = 8'h00;
        foreach (recent[i]) recent[i] = 8'h00;
        foreach (class_tally[i]) class_tally[i] = 0;
        scan_count = 0;
        {csv_quoted, csv_ended, csv_comma, ofx_found, ofx_nul} = '0;
        {png_found, jpeg_found} = '0;
        {png_w, png_h, jpeg_w, jpeg_h} = '0;
    endtask

    task automatic scan_byte(logic [7:0] b);
        int q;
        q = scan_count;
        if (q < 10) hdr[q] = b;
        for (int i = 15; i > 0; i--) recent[i] = recent[i - 1];
        recent[0] = b;
        class_tally[byte_class(b)]++;
        if (!csv_ended)
        begin
            if (b == "\"") csv_quoted = !csv_quoted;
            else if (b == "," && !csv_quoted) csv_comma = 1;
            else if (b == 8'h0a || b == 8'h0d) csv_ended = 1;
        end
        if (b == 8'h00)
        begin
            ofx_nul = 1;
        end
        else if (!ofx_nul && !ofx_found)
        begin
            if (recent_ends_with("<?xml version=", q + 1) ||
                recent_ends_with("<?OFX OFXHEADER=", q + 1) ||
                recent_ends_with("OFXHEADER:", q + 1))
                ofx_found = 1;
        end
        if (!png_found && q >= 11 && recent[11] == 8'h49 && recent[10] == 8'h48 &&
            recent[9] == 8'h44 && recent[8] == 8'h52)
        begin
            png_found = 1;
            png_w = {recent[5], recent[4]};
            png_h = {recent[1], recent[0]};
        end
        if (!jpeg_found && q >= 9 && recent[9] == 8'hff && recent[8] == 8'hc0)
        begin
            jpeg_found = 1;
            jpeg_h = {recent[4], recent[3]};
            jpeg_w = {recent[2], recent[1]};
        end
        scan_count = q + 1;
    endtask

    function automatic bit header_is(logic [63:0] sig, int len);
        if (scan_count < len) return 0;
        for (int i = 0; i < len; i++)
        begin
            if (hdr[i] != sig[8 * i +: 8]) return 0;
        end
        return 1;
    endfunction

    function automatic bit looks_like_text();
        longint n, np, al, nu, pu, ot;
        n = scan_count;
        np = class_tally[fts_pkg::CL_NOPRINT];
        al = class_tally[fts_pkg::CL_ALPHA];
        nu = class_tally[fts_pkg::CL_NUMBER];
        pu = class_tally[fts_pkg::CL_PUNCT];
        ot = class_tally[fts_pkg::CL_OTHER];
        if (20 * np > n) return 0;
        if (10 * nu > al) return 0;
        if (50 * ot > al + nu + pu) return 0;
        return 1;
    endfunction

    function automatic verdict_t classify_buffer();
        verdict_t v;
        v = '0;
        if (header_is(fts_pkg::SIG_PNG, 8))
        begin
            v.file_type = fts_pkg::FT_PNG;
            if (png_found) {v.image_width, v.image_height} = {png_w, png_h};
        end
        else if (header_is(fts_pkg::SIG_ARCH, 7)) v.file_type = fts_pkg::FT_ARCHIVE;
        else if (header_is(fts_pkg::SIG_GIF89, 6) || header_is(fts_pkg::SIG_GIF87, 6))
        begin
            v.file_type = fts_pkg::FT_GIF;
            v.image_width = {hdr[7], hdr[6]};
            v.image_height = {hdr[9], hdr[8]};
        end
        else if (header_is(fts_pkg::SIG_QIF, 6)) v.file_type = fts_pkg::FT_QIF;
        else if (header_is(fts_pkg::SIG_PDF, 4)) v.file_type = fts_pkg::FT_PDF;
        else if (header_is(fts_pkg::SIG_OFFICE, 4)) v.file_type = fts_pkg::FT_OFFICE;
        else if (header_is(fts_pkg::SIG_ELF, 4)) v.file_type = fts_pkg::FT_ELF;
        else if (header_is(fts_pkg::SIG_JPEG, 3))
        begin
            if (scan_count >= 10 && hdr[6] == "E" && hdr[7] == "x" && hdr[8] == "i" &&
                hdr[9] == "f")
            begin
                v.file_type = fts_pkg::FT_EXIF;
            end
            else
            begin
                v.file_type = fts_pkg::FT_JPEG;
                if (jpeg_found) {v.image_width, v.image_height} = {jpeg_w, jpeg_h};
            end
        end
        else if (header_is(fts_pkg::SIG_PS, 2)) v.file_type = fts_pkg::FT_PS;
        else if (header_is(fts_pkg::SIG_ZIP, 2)) v.file_type = fts_pkg::FT_ZIP;
        else if (header_is(fts_pkg::SIG_SHELL, 2)) v.file_type = fts_pkg::FT_SHELL;
        else if (header_is(fts_pkg::SIG_MZ, 2)) v.file_type = fts_pkg::FT_MZ;
        else if (header_is(fts_pkg::SIG_ZM, 2)) v.file_type = fts_pkg::FT_ZM;
        else if (looks_like_text()) v.file_type = fts_pkg::FT_TEXT;
        else if (csv_comma) v.file_type = fts_pkg::FT_CSV;
        else if (ofx_found) v.file_type = fts_pkg::FT_OFX;
        v.executable = (v.file_type == fts_pkg::FT_ELF || v.file_type == fts_pkg::FT_SHELL ||
                        v.file_type == fts_pkg::FT_MZ || v.file_type == fts_pkg::FT_ZM);
        v.image_area = 32'(v.image_width) * 32'(v.image_height);
        return v;
    endfunction

    // Queues one buffer and predicts its verdict at once.
    task automatic send_buffer(logic [7:0] buf_bytes[$]);
        byte_item_t it;
        foreach (buf_bytes[i])
        begin
            it.data_byte = buf_bytes[i];
            it.last_byte = (i == buf_bytes.size() - 1);
            pending_bytes.push_back(it);
            if (scan_count < MAX_BYTES) scan_byte(buf_bytes[i]);
        end
        expected_verdicts.push_back(classify_buffer());
        clear_scan();
    endtask

    task automatic send_string(string s);
        logic [7:0] b[$];
        for (int i = 0; i < s.len(); i++) b.push_back(s[i]);
        send_buffer(b);
    endtask

    function automatic logic [7:0] random_printable();
        return 8'($urandom_range(8'h20, 8'h7e));
    endfunction

    task automatic fill_random(ref logic [7:0] b[$], input int len, input int flavor);
        for (int i = 0; i < len; i++)
        begin
            case (flavor)
                0: b.push_back(8'($urandom));
                1: b.push_back($urandom_range(0, 9) == 0 ? 8'h0a : random_printable());
                default: b.push_back($urandom_range(0, 3) == 0 ? "," :
                                     8'($urandom_range("a", "z")));
            endcase
        end
    endtask

    task automatic send_random_buffer();
        logic [7:0] b[$];
        int kind;
        int len;
        kind = $urandom_range(0, 11);
        len = $urandom_range(1, 24);
        case (kind)
            0:
            begin
                b = '{8'h89, 8'h50, 8'h4e, 8'h47, 8'h0d, 8'h0a, 8'h1a, 8'h0a};
                fill_random(b, $urandom_range(0, 4), 0);
                b.push_back(8'h00);
                b.push_back(8'h00);
                b.push_back(8'h00);
                b.push_back(8'h0d);
                b.push_back("I");
                b.push_back("H");
                b.push_back("D");
                b.push_back("R");
                fill_random(b, $urandom_range(0, 10), 0);
            end
            1:
            begin
                b = '{8'hff, 8'hd8, 8'hff};
                fill_random(b, $urandom_range(0, 8), 0);
                if ($urandom_range(0, 3) == 0 && b.size() >= 10)
                begin
                    b[6] = "E";
                    b[7] = "x";
                    b[8] = "i";
                    b[9] = "f";
                end
                b.push_back(8'hff);
                b.push_back(8'hc0);
                fill_random(b, $urandom_range(0, 10), 0);
            end
            2:
            begin
                b = '{"G", "I", "F", "8", $urandom_range(0, 1) ? "9" : "7", "a"};
                fill_random(b, $urandom_range(0, 6), 0);
            end
            3:
            begin
                case ($urandom_range(0, 9))
                    0: b = '{"!", "<", "a", "r", "c", "h", ">"};
                    1: b = '{"!", "T", "y", "p", "e", ":"};
                    2: b = '{"%", "P", "D", "F"};
                    3: b = '{8'hd0, 8'hcf, 8'h11, 8'he0};
                    4: b = '{8'h7f, "E", "L", "F"};
                    5: b = '{"%", "!"};
                    6: b = '{"P", "K"};
                    7: b = '{"#", "!"};
                    8: b = '{"M", "Z"};
                    default: b = '{"Z", "M"};
                endcase
                if ($urandom_range(0, 3) == 0) void'(b.pop_back());
                fill_random(b, $urandom_range(0, 8), 0);
            end
            4, 5: fill_random(b, len, 1);
            6: fill_random(b, len, 2);
            7:
            begin
                string pat;
                case ($urandom_range(0, 2))
                    0: pat = "<?xml version=";
                    1: pat = "<?OFX OFXHEADER=";
                    default: pat = "OFXHEADER:";
                endcase
                fill_random(b, $urandom_range(0, 6), $urandom_range(0, 1) ? 0 : 1);
                if ($urandom_range(0, 3) == 0) b.push_back(8'h00);
                for (int i = 0; i < pat.len(); i++) b.push_back(pat[i]);
                fill_random(b, $urandom_range(0, 4), 1);
            end
            default: fill_random(b, len, 0);
        endcase
        send_buffer(b);
    endtask

    // Keeps the byte queue short so prediction stays near the bytes being driven.
    task automatic send_random_buffer_wait();
        wait (pending_bytes.size() < 64);
        send_random_buffer();
    endtask

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch in buffer %0d: %s got %0d expected %0d",
                 buffers_checked, field, got, want);
        mismatch_count++;
    endtask

    // Byte driver: waits a drawn number of cycles before each byte and changes
    // inputs on the falling edge.
    initial
    begin
        bytes.valid = 1'b0;
        bytes.data_byte = 8'h00;
        bytes.last_byte = 1'b0;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (byte_taken)
            begin
                void'(pending_bytes.pop_front());
                bytes_sent++;
                in_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 8) : 0;
            end
            if (bytes.valid && !byte_taken)
            begin
                bytes.valid <= 1'b1;
            end
            else if (in_gap > 0)
            begin
                in_gap--;
                bytes.valid <= 1'b0;
            end
            else if (pending_bytes.size() > 0)
            begin
                bytes.valid <= 1'b1;
                bytes.data_byte <= pending_bytes[0].data_byte;
                bytes.last_byte <= pending_bytes[0].last_byte;
            end
            else
            begin
                bytes.valid <= 1'b0;
            end
        end
    end

    // Result sink: a drawn wait before each item, plus a long hold-off when asked.
    initial result.ready = 1'b0;

    always @(negedge clk)
    begin
        if (!rst_n || hold_result)
        begin
            result.ready <= 1'b0;
        end
        else if (result_taken)
        begin
            out_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 8) : 0;
            result.ready <= (out_gap == 0);
        end
        else if (out_gap > 0)
        begin
            out_gap--;
            result.ready <= (out_gap == 0);
        end
        else
        begin
            result.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        verdict_t want;
        byte_taken = rst_n && bytes.valid && bytes.ready;
        result_taken = rst_n && result.valid && result.ready;
        if (rst_n)
        begin
            idle_cycles++;
            if (byte_taken) idle_cycles = 0;
            if (result_taken)
            begin
                idle_cycles = 0;
                if (expected_verdicts.size() == 0)
                begin
                    $display("result with no buffer pending, type %0d", result.file_type);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (result.file_type !== want.file_type)
                        report_mismatch("file_type", result.file_type, want.file_type);
                    if (result.executable !== want.executable)
                        report_mismatch("executable", result.executable, want.executable);
                    if (result.image_width !== want.image_width)
                        report_mismatch("image_width", result.image_width, want.image_width);
                    if (result.image_height !== want.image_height)
                        report_mismatch("image_height", result.image_height,
                                        want.image_height);
                    if (result.image_area !== want.image_area)
                        report_mismatch("image_area", result.image_area, want.image_area);
                    if (want.file_type <= fts_pkg::FT_OFX) type_seen[want.file_type]++;
                    buffers_checked++;
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT && !hold_result)
            begin
                $display("watchdog expired with %0d results outstanding",
                         expected_verdicts.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] b[$];
        int types_hit;
        rst_n = 1'b0;
        hold_result = 1'b0;
        byte_taken = 1'b0;
        result_taken = 1'b0;
        in_gap = 0;
        out_gap = 0;
        clear_scan();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_string("GIF89a");
        b = '{"G", "I", "F", "8", "7", "a", 8'hff, 8'hff, 8'hff, 8'hff};
        send_buffer(b);
        b = '{"G", "I", "F", "8", "9", "a", 8'h34, 8'h12};
        send_buffer(b);
        b = '{8'h89, 8'h50, 8'h4e, 8'h47, 8'h0d, 8'h0a, 8'h1a, 8'h0a, 8'h00, 8'h00, 8'h00,
              8'h0d, "I", "H", "D", "R", 8'h00, 8'h00, 8'hff, 8'hff, 8'h00, 8'h00,
              8'hff, 8'hff};
        send_buffer(b);
        b = '{8'h89, 8'h50, 8'h4e, 8'h47, 8'h0d, 8'h0a, 8'h1a};
        send_buffer(b);
        b = '{8'hff, 8'hd8, 8'hff, 8'he0, 8'hff, 8'hc0, 8'h00, 8'h11, 8'h08, 8'h01,
              8'h00, 8'h02, 8'h00};
        send_buffer(b);
        b = '{8'hff, 8'hd8, 8'hff, 8'he1, 8'h00, 8'h10, "E", "x", "i", "f"};
        send_buffer(b);
        send_string("!<arch>");
        send_string("!Type:");
        send_string("%PDF");
        b = '{8'hd0, 8'hcf, 8'h11, 8'he0};
        send_buffer(b);
        b = '{8'h7f, "E", "L", "F"};
        send_buffer(b);
        send_string("%!");
        send_string("PK");
        send_string("#!");
        send_string("MZ");
        send_string("ZM");
        send_string("Z");
        send_string("plain words here");
        b = '{8'h01, 8'h80, "a", ",", "b", "\"", ",", "\"", 8'h0a, ","};
        send_buffer(b);
        b = '{8'h01, 8'h02, 8'h03, "<", "?", "x", "m", "l", " ", "v", "e", "r", "s", "i", "o",
              "n", "="};
        send_buffer(b);
        b = '{8'h01, 8'h00, "O", "F", "X", "H", "E", "A", "D", "E", "R", ":"};
        send_buffer(b);
        b = '{8'h00};
        send_buffer(b);

        wait (pending_bytes.size() == 0);
        // Stall the result side long enough for the block to back up its input.
        hold_result = 1'b1;
        for (int i = 0; i < 8; i++) send_string("ZM stall");
        repeat (300) @(posedge clk);
        hold_result = 1'b0;

        while (bytes_sent < ITEM_TARGET) send_random_buffer_wait();

        wait (pending_bytes.size() == 0);
        wait (expected_verdicts.size() == 0);
        repeat (10) @(posedge clk);
        types_hit = 0;
        foreach (type_seen[i]) if (type_seen[i] > 0) types_hit++;
        $display("Checked %0d buffers from %0d bytes; %0d of 18 file types produced.",
                 buffers_checked, bytes_sent, types_hit);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
